[rtl/huf_cb_pkg.sv]
package huf_cb_pkg;

  // input transaction: one symbol weight
  typedef struct packed {
    logic [15:0] weight;
    logic        last_weight;
  } in_t;

  // result transaction: one code per symbol
  typedef struct packed {
    logic [4:0]  symbol;
    logic [30:0] code_bits;
    logic [4:0]  code_length;
    logic        last_code;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic build;
    logic scan_init;
    logic scan_issue;
    logic merge_a;
    logic merge_b;
    logic emit_init;
    logic walk_left;
    logic walk_step;
    logic emit_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_in;
    logic single;
    logic scan_last;
    logic merge_more;
    logic has_parent;
    logic last_sym;
  } sts_t;

endpackage

[rtl/huf_cb_ram.sv]
module huf_cb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/huf_cb_ctrl.sv]
module huf_cb_ctrl
  import huf_cb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SCAN      = 10'b00_0000_0010,
    S_SCAN_END  = 10'b00_0000_0100,
    S_MERGE_A   = 10'b00_0000_1000,
    S_MERGE_B   = 10'b00_0001_0000,
    S_EMIT_INIT = 10'b00_0010_0000,
    S_WALK_P    = 10'b00_0100_0000,
    S_WALK_L    = 10'b00_1000_0000,
    S_WALK_C    = 10'b01_0000_0000,
    S_OUT       = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.last_in) begin
            cmd.build     = 1'b1;
            cmd.scan_init = 1'b1;
            state_nxt     = sts.single ? S_EMIT_INIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: state_nxt = S_MERGE_A;
      S_MERGE_A: begin
        cmd.merge_a = 1'b1;
        state_nxt   = S_MERGE_B;
      end
      S_MERGE_B: begin
        cmd.merge_b   = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = sts.merge_more ? S_SCAN : S_EMIT_INIT;
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_nxt     = S_WALK_P;
      end
      S_WALK_P: state_nxt = sts.has_parent ? S_WALK_L : S_OUT;
      S_WALK_L: begin
        cmd.walk_left = 1'b1;
        state_nxt     = S_WALK_C;
      end
      S_WALK_C: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WALK_P;
      end
      S_OUT: begin
        cmd.emit_out = 1'b1;
        state_nxt    = sts.last_sym ? S_IDLE : S_EMIT_INIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // a build never enters the merge phase without scanning first
  a_merge_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE_A |-> $past(state_r) == S_SCAN_END)
    else $error("merge without scan");

  // the last result returns the block to idle
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && sts.last_sym |=> state_r == S_IDLE)
    else $error("no return to idle after last code");

  // a load without the last mark keeps the block idle
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && start && !sts.last_in |=> state_r == S_IDLE)
    else $error("plain load left idle");

endmodule

[rtl/huf_cb_dp.sv]
module huf_cb_dp
  import huf_cb_pkg::*;
#(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_data
);

  localparam int NODES = 2 * MAX_SYMBOLS;
  localparam int NW    = $clog2(NODES);
  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int WW    = 16 + $clog2(MAX_SYMBOLS);
  localparam int AW    = WW + 1;

  logic [CW-1:0]    count_r, n_r, n_nxt;
  logic [NW-1:0]    i_r, k_r, kd_r, l_r, r_r;
  logic [NW-1:0]    s_r, c_r, f_r, len_r;
  logic             pend_r;
  logic [AW-1:0]    a_r, b_r, big;
  logic [NODES-1:0] hasp_r;
  logic [30:0]      code_r;

  logic             wt_we;
  logic [NW-1:0]    wt_waddr;
  logic [WW-1:0]    wt_wdata, wt_rdata;
  logic [NW-1:0]    par_waddr, par_rdata, left_rdata;
  logic             a_ge, take;

  // symbol count after this load
  assign n_nxt = (count_r < CW'(MAX_SYMBOLS)) ? count_r + 1'b1 : count_r;

  // weight store write: leaf load or merged node
  always_comb begin
    wt_we    = 1'b0;
    wt_waddr = i_r;
    wt_wdata = WW'(a_r + b_r);
    if (cmd.load && (count_r < CW'(MAX_SYMBOLS))) begin
      wt_we    = 1'b1;
      wt_waddr = NW'(count_r) + 1'b1;
      wt_wdata = WW'(in_data.weight);
    end else if (cmd.merge_a) begin
      wt_we = 1'b1;
    end
  end

  assign par_waddr = cmd.merge_a ? l_r : r_r;

  huf_cb_ram #(.WIDTH(WW), .DEPTH(NODES)) u_weight (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(k_r), .rdata(wt_rdata)
  );

  huf_cb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_parent (
    .clk(clk), .we(cmd.merge_a | cmd.merge_b), .waddr(par_waddr), .wdata(i_r),
    .raddr(c_r), .rdata(par_rdata)
  );

  huf_cb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_left (
    .clk(clk), .we(cmd.merge_a), .waddr(i_r), .wdata(l_r),
    .raddr(par_rdata), .rdata(left_rdata)
  );

  // running minima compare; a tie replaces a
  assign a_ge = (a_r >= b_r);
  assign big  = a_ge ? a_r : b_r;
  assign take = pend_r && !hasp_r[kd_r] && (AW'(wt_rdata) <= big);

  // control counters and parent flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      hasp_r  <= '0;
    end else begin
      if (cmd.load) begin
        count_r <= n_nxt;
      end
      if (cmd.emit_out && sts.last_sym) begin
        count_r <= '0;
      end
      pend_r <= cmd.scan_issue;
      if (cmd.build) begin
        hasp_r <= '0;
      end else if (cmd.merge_a) begin
        hasp_r <= hasp_r | (NODES'(1) << l_r) | (NODES'(1) << r_r);
      end
    end
  end

  // build, scan and code walk registers
  always_ff @(posedge clk) begin
    if (cmd.build) begin
      n_r <= n_nxt;
      i_r <= NW'(n_nxt) + 1'b1;
      s_r <= NW'(1);
    end
    if (cmd.scan_init) begin
      a_r <= '1;
      b_r <= '1;
      l_r <= NW'(1);
      r_r <= NW'(2);
      k_r <= NW'(1);
    end else begin
      if (cmd.scan_issue) begin
        k_r  <= k_r + 1'b1;
        kd_r <= k_r;
      end
      if (take) begin
        if (a_ge) begin
          a_r <= AW'(wt_rdata);
          l_r <= kd_r;
        end else begin
          b_r <= AW'(wt_rdata);
          r_r <= kd_r;
        end
      end
    end
    if (cmd.merge_b) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.emit_init) begin
      c_r    <= s_r;
      code_r <= '0;
      len_r  <= '0;
    end
    if (cmd.walk_left) begin
      f_r <= par_rdata;
    end
    if (cmd.walk_step) begin
      if (left_rdata != c_r) begin
        code_r <= code_r | (31'(1) << len_r);
      end
      len_r <= len_r + 1'b1;
      c_r   <= f_r;
    end
    if (cmd.emit_out) begin
      s_r <= s_r + 1'b1;
    end
  end

  // status
  assign sts.last_in    = in_data.last_weight;
  assign sts.single     = (n_nxt == CW'(1));
  assign sts.scan_last  = (k_r == i_r - 1'b1);
  assign sts.merge_more = ((NW + 1)'(i_r) + 1'b1) < (NW + 1)'({n_r, 1'b0});
  assign sts.has_parent = hasp_r[c_r];
  assign sts.last_sym   = (s_r == NW'(n_r));

  // result fields
  assign out_data.symbol      = 5'(s_r - 1'b1);
  assign out_data.code_bits   = code_r;
  assign out_data.code_length = 5'(len_r);
  assign out_data.last_code   = sts.last_sym;

endmodule

[rtl/huffman_code_builder_core.sv]
// a load without the last mark gives no result; the next load follows at once
// a build over n symbols scans the weight memory for the two smallest free nodes before each merge,
// then walks each symbol's leaf up to the root to form its code
// one result strobe per symbol, in symbol order; busy holds off loads until the last code
// reset (synchronous, active low) clears the controller, symbol count and flags
module huffman_code_builder_core
  import huf_cb_pkg::*;
#(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  huf_cb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  huf_cb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );

  // results appear only during a build
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  // a build ends right after the last code
  a_end_of_build: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid && out_data.last_code))
    else $error("build ended without last code");

  // the final code is a single transaction
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_code |=> !out_valid)
    else $error("result after last code");

endmodule
